// ===== hw/rtl/crs2d_pkg.sv =====
// Shared widths, constants and item types of the 2-D Catmull-Rom spline block.
package crs2d_pkg;

  // Coordinate and position formats.
  localparam int COORD_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int T_W       = FRAC_W + 1;

  // Coefficient width: the largest coefficient sum is twelve times a coordinate.
  localparam int COEF_W    = COORD_W + 4;

  // Accumulator: integer part holds twice the spline value with overshoot headroom.
  localparam int HI_W      = COORD_W + 5;
  localparam int ACC_W     = HI_W + FRAC_W;

  // Partial product widths of one Horner step.
  localparam int PH_W      = HI_W + T_W + 1;
  localparam int PL_W      = FRAC_W + T_W;

  // Horner steps after the leading coefficient.
  localparam int NUM_STEPS = 3;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_W{1'b0}}};

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // One input item: four control points and the position.
  typedef struct packed {
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic [T_W-1:0]            position;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      clipped;
  } out_item_t;

  // Remaining coefficients, the next one to add in the lowest slot.
  typedef logic [NUM_STEPS-1:0][COEF_W-1:0] coef_queue_t;

  // Accumulator state of both axes between Horner steps.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    coef_queue_t             coef_x;
    coef_queue_t             coef_y;
    logic [T_W-1:0]          t;
  } work_t;

endpackage

// ===== hw/rtl/crs2d_coef.sv =====
// Entry stage: forms the spline coefficients and clamps the position.
module crs2d_coef import crs2d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_stall,
  input  in_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_stall,
  output work_t    dn_work
);

  logic  vld;
  logic  hold;
  work_t work;
  work_t work_next;

  // Coefficients of one axis, returned as the leading accumulator and the queue.
  function automatic logic [ACC_W+NUM_STEPS*COEF_W-1:0] axis_coef(
    logic signed [COORD_W-1:0] p0, logic signed [COORD_W-1:0] p1,
    logic signed [COORD_W-1:0] p2, logic signed [COORD_W-1:0] p3);
    logic signed [COEF_W-1:0] e0, e1, e2, e3;
    logic signed [COEF_W-1:0] c0, c1, c2, c3;
    coef_queue_t              q;
    e0 = COEF_W'(p0);
    e1 = COEF_W'(p1);
    e2 = COEF_W'(p2);
    e3 = COEF_W'(p3);
    c0 = e1 <<< 1;
    c1 = e2 - e0;
    c2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c3 = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
    q[0] = c2;
    q[1] = c1;
    q[2] = c0;
    return {HI_W'(c3), {FRAC_W{1'b0}}, q};
  endfunction

  // Coefficients for both axes and the clamped position.
  always_comb begin
    {work_next.acc_x, work_next.coef_x} =
      axis_coef(up_item.p0_x, up_item.p1_x, up_item.p2_x, up_item.p3_x);
    {work_next.acc_y, work_next.coef_y} =
      axis_coef(up_item.p0_y, up_item.p1_y, up_item.p2_y, up_item.p3_y);
    work_next.t = (up_item.position > T_ONE) ? T_ONE : up_item.position;
  end

  assign hold     = vld && dn_stall;
  assign up_stall = hold;

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!hold) begin
      vld <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_valid && !hold) begin
      work <= work_next;
    end
  end

  assign dn_valid = vld;
  assign dn_work  = work;

  a_t_clamped: assert property (@(posedge clk) disable iff (rst)
    vld |-> work.t <= T_ONE)
    else $error("position above one left the entry stage");

endmodule

// ===== hw/rtl/crs2d_step.sv =====
// One Horner step: acc = floor(acc*t / 2^F) + (c << F), split over two stages.
module crs2d_step import crs2d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_stall,
  input  work_t up_work,
  output logic  dn_valid,
  input  logic  dn_stall,
  output work_t dn_work
);

  typedef struct packed {
    logic signed [PH_W-1:0] ph;
    logic [PL_W-1:0]        pl;
  } prod_t;

  typedef struct packed {
    prod_t          pr_x;
    prod_t          pr_y;
    coef_queue_t    coef_x;
    coef_queue_t    coef_y;
    logic [T_W-1:0] t;
  } mid_t;

  logic  mul_vld;
  logic  add_vld;
  logic  mul_hold;
  logic  add_hold;
  mid_t  mid;
  mid_t  mid_next;
  work_t work;
  work_t work_next;

  // Integer and fraction parts of the accumulator times t.
  function automatic prod_t mul_part(logic signed [ACC_W-1:0] acc, logic [T_W-1:0] t);
    prod_t                  r;
    logic signed [HI_W-1:0] hi;
    logic [FRAC_W-1:0]      lo;
    hi   = acc[ACC_W-1:FRAC_W];
    lo   = acc[FRAC_W-1:0];
    r.ph = hi * $signed({1'b0, t});
    r.pl = lo * t;
    return r;
  endfunction

  // Recombine the partial products and add the next coefficient.
  function automatic logic [ACC_W-1:0] add_part(prod_t p, logic [COEF_W-1:0] c);
    logic signed [COEF_W-1:0] cs;
    cs = c;
    return p.ph[ACC_W-1:0] + ACC_W'(p.pl[PL_W-1:FRAC_W]) + {HI_W'(cs), {FRAC_W{1'b0}}};
  endfunction

  // Multiply stage.
  always_comb begin
    mid_next.pr_x   = mul_part(up_work.acc_x, up_work.t);
    mid_next.pr_y   = mul_part(up_work.acc_y, up_work.t);
    mid_next.coef_x = up_work.coef_x;
    mid_next.coef_y = up_work.coef_y;
    mid_next.t      = up_work.t;
  end

  // Add stage; the used coefficient leaves the queue.
  always_comb begin
    work_next.acc_x  = add_part(mid.pr_x, mid.coef_x[0]);
    work_next.acc_y  = add_part(mid.pr_y, mid.coef_y[0]);
    work_next.coef_x = mid.coef_x >> COEF_W;
    work_next.coef_y = mid.coef_y >> COEF_W;
    work_next.t      = mid.t;
  end

  assign add_hold = add_vld && dn_stall;
  assign mul_hold = mul_vld && add_hold;
  assign up_stall = mul_hold;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      add_vld <= 1'b0;
    end else begin
      if (!mul_hold) begin
        mul_vld <= up_valid;
      end
      if (!add_hold) begin
        add_vld <= mul_vld;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (up_valid && !mul_hold) begin
      mid <= mid_next;
    end
    if (mul_vld && !add_hold) begin
      work <= work_next;
    end
  end

  assign dn_valid = add_vld;
  assign dn_work  = work;

endmodule

// ===== hw/rtl/crs2d_round.sv =====
// Exit stage: halves with round half up, saturates and holds the result item.
module crs2d_round import crs2d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_stall,
  input  work_t     up_work,
  output logic      dn_valid,
  input  logic      dn_stall,
  output out_item_t dn_item
);

  logic      vld;
  logic      hold;
  out_item_t item;
  out_item_t item_next;
  logic      sat_x;
  logic      sat_y;

  // floor((acc + 2^F) / 2^(F+1)) saturated; the top bit reports saturation.
  function automatic logic [COORD_W:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]  rnd;
    logic signed [HI_W-1:0] v;
    rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(T_ONE);
    v   = HI_W'(rnd >>> (FRAC_W + 1));
    if (v > HI_W'(COORD_MAX)) begin
      return {1'b1, COORD_MAX};
    end else if (v < HI_W'(COORD_MIN)) begin
      return {1'b1, COORD_MIN};
    end
    return {1'b0, v[COORD_W-1:0]};
  endfunction

  always_comb begin
    {sat_x, item_next.out_x} = round_sat(up_work.acc_x);
    {sat_y, item_next.out_y} = round_sat(up_work.acc_y);
    item_next.clipped        = sat_x || sat_y;
  end

  assign hold     = vld && dn_stall;
  assign up_stall = hold;

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!hold) begin
      vld <= up_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (up_valid && !hold) begin
      item <= item_next;
    end
  end

  assign dn_valid = vld;
  assign dn_item  = item;

  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    vld && item.clipped |->
      item.out_x == COORD_MAX || item.out_x == COORD_MIN ||
      item.out_y == COORD_MAX || item.out_y == COORD_MIN)
    else $error("clipped item has no coordinate at a bound");

endmodule

// ===== hw/rtl/catmull_rom_spline_2d_top.sv =====
// Top level of the 2-D uniform Catmull-Rom spline interpolator.
// Each item carries four control points and a position t (16 fraction bits, values above
// one are taken as one); the block returns the spline point between the second and third
// points, per axis rounded half up and saturated to 16 bits, with clipped set when either
// axis saturated. The pipeline has eight register stages: coefficient forming, three Horner
// steps of two stages each (multiply, then recombine and add), and the rounding stage that
// is also the output register. It takes one item per cycle unless the output stalls;
// each Horner step has its own multipliers, so nothing is shared between items. Stalls move
// back stage by stage, so bubbles close up and a full pipeline holds eight items.
module catmull_rom_spline_2d_top import crs2d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      ctrl_valid,
  output logic      ctrl_stall,
  input  in_item_t  ctrl,
  output logic      curve_valid,
  input  logic      curve_stall,
  output out_item_t curve
);

  logic  valid_c [NUM_STEPS+1];
  logic  stall_c [NUM_STEPS+1];
  work_t work_c  [NUM_STEPS+1];

  // Coefficient forming.
  crs2d_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ctrl_valid),
    .up_stall (ctrl_stall),
    .up_item  (ctrl),
    .dn_valid (valid_c[0]),
    .dn_stall (stall_c[0]),
    .dn_work  (work_c[0])
  );

  // Horner steps for t^2, t and the constant term.
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    crs2d_step u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid_c[i]),
      .up_stall (stall_c[i]),
      .up_work  (work_c[i]),
      .dn_valid (valid_c[i+1]),
      .dn_stall (stall_c[i+1]),
      .dn_work  (work_c[i+1])
    );
  end

  // Rounding, saturation and output register.
  crs2d_round u_round (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid_c[NUM_STEPS]),
    .up_stall (stall_c[NUM_STEPS]),
    .up_work  (work_c[NUM_STEPS]),
    .dn_valid (curve_valid),
    .dn_stall (curve_stall),
    .dn_item  (curve)
  );

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    ctrl_stall |-> curve_valid && curve_stall)
    else $error("input stalled while the output register could move");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !curve_valid)
    else $error("result shown straight after reset");

endmodule

// ===== tb/sv/catmull_rom_spline_2d_top_test.sv =====
// Self-checking testbench of the 2-D Catmull-Rom spline top level, directed table then random items.
module catmull_rom_spline_2d_top_test;
  import crs2d_pkg::*;

  localparam int RANDOM_PER_PHASE = 610;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 16;

  // One row of the directed table: the item and, where known at a glance, its result.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } table_row_t;

  logic      clk;
  logic      rst;
  logic      ctrl_valid;
  logic      ctrl_stall;
  in_item_t  ctrl;
  logic      curve_valid;
  logic      curve_stall = 1'b0;
  out_item_t curve;

  // Result of the row being offered, used instead of the predictor when typed.
  bit        row_typed = 1'b0;
  out_item_t row_want  = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;

  out_item_t  pending_points[$];
  out_item_t  oldest;
  table_row_t directed_rows[$];

  catmull_rom_spline_2d_top uut (
    .clk         (clk),
    .rst         (rst),
    .ctrl_valid  (ctrl_valid),
    .ctrl_stall  (ctrl_stall),
    .ctrl        (ctrl),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .curve       (curve)
  );

  // Clock with a period of 12.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One axis of the spline: Horner's rule with FRAC_W fraction bits, then round and saturate.
  function automatic logic signed [COORD_W-1:0] spline_axis(
    input logic signed [COORD_W-1:0] a0, input logic signed [COORD_W-1:0] a1,
    input logic signed [COORD_W-1:0] a2, input logic signed [COORD_W-1:0] a3,
    input longint t, inout bit clip);
    longint q0, q1, q2, q3;
    longint k0, k1, k2, k3;
    longint scale, acc, v;
    q0 = a0;
    q1 = a1;
    q2 = a2;
    q3 = a3;
    k0 = 2 * q1;
    k1 = q2 - q0;
    k2 = 2 * q0 - 5 * q1 + 4 * q2 - q3;
    k3 = -q0 + 3 * q1 - 3 * q2 + q3;
    scale = longint'(1) <<< FRAC_W;
    acc = k3 * scale;
    acc = ((acc * t) >>> FRAC_W) + k2 * scale;
    acc = ((acc * t) >>> FRAC_W) + k1 * scale;
    acc = ((acc * t) >>> FRAC_W) + k0 * scale;
    v = (acc + scale) >>> (FRAC_W + 1);
    if (v > longint'(COORD_MAX)) begin
      v = COORD_MAX;
      clip = 1'b1;
    end else if (v < longint'(COORD_MIN)) begin
      v = COORD_MIN;
      clip = 1'b1;
    end
    return v[COORD_W-1:0];
  endfunction

  // Expected spline point of one item; a position above one counts as one.
  function automatic out_item_t spline_point(input in_item_t it);
    out_item_t r;
    longint    t;
    bit        clip;
    clip = 1'b0;
    t = it.position;
    if (t > longint'(T_ONE))
      t = T_ONE;
    r.out_x   = spline_axis(it.p0_x, it.p1_x, it.p2_x, it.p3_x, t, clip);
    r.out_y   = spline_axis(it.p0_y, it.p1_y, it.p2_y, it.p3_y, t, clip);
    r.clipped = clip;
    return r;
  endfunction

  function automatic in_item_t make_item(
    input logic signed [COORD_W-1:0] x0, input logic signed [COORD_W-1:0] y0,
    input logic signed [COORD_W-1:0] x1, input logic signed [COORD_W-1:0] y1,
    input logic signed [COORD_W-1:0] x2, input logic signed [COORD_W-1:0] y2,
    input logic signed [COORD_W-1:0] x3, input logic signed [COORD_W-1:0] y3,
    input logic [T_W-1:0] t);
    in_item_t it;
    it.p0_x = x0;
    it.p0_y = y0;
    it.p1_x = x1;
    it.p1_y = y1;
    it.p2_x = x2;
    it.p2_y = y2;
    it.p3_x = x3;
    it.p3_y = y3;
    it.position = t;
    return it;
  endfunction

  function automatic out_item_t make_point(
    input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y, input logic c);
    out_item_t r;
    r.out_x   = x;
    r.out_y   = y;
    r.clipped = c;
    return r;
  endfunction

  task automatic add_row(input in_item_t it, input bit typed, input out_item_t want);
    table_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // One coordinate drawn from a mix of full range, small values and the extremes.
  function automatic logic signed [COORD_W-1:0] random_coord(input int unsigned kind);
    logic signed [COORD_W-1:0] c;
    case (kind)
      0: c = COORD_W'($urandom_range(511) - 256);
      1: begin
        case ($urandom_range(4))
          0: c = COORD_MAX;
          1: c = COORD_MIN;
          2: c = '0;
          3: c = COORD_W'(-1);
          default: c = 1;
        endcase
      end
      default: c = COORD_W'($urandom);
    endcase
    return c;
  endfunction

  // A random item; most positions lie within [0, one], some above it.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned kind;
    int unsigned pick;
    pick = $urandom_range(9);
    kind = (pick < 6) ? 2 : (pick < 8) ? 0 : 1;
    it.p0_x = random_coord(kind);
    it.p0_y = random_coord(kind);
    it.p1_x = random_coord(kind);
    it.p1_y = random_coord(kind);
    it.p2_x = random_coord(kind);
    it.p2_y = random_coord(kind);
    it.p3_x = random_coord(kind);
    it.p3_y = random_coord(kind);
    pick = $urandom_range(19);
    if (pick == 0)
      it.position = '0;
    else if (pick == 1)
      it.position = T_ONE;
    else if (pick < 4)
      it.position = T_W'($urandom_range((1 << T_W) - 1, T_ONE + 1));
    else
      it.position = T_W'($urandom_range(T_ONE));
    return it;
  endfunction

  // Offers one item after a random gap and holds it until it is accepted.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      ctrl_valid = 1'b0;
      @(negedge clk);
    end
    ctrl       = it;
    row_typed  = typed;
    row_want   = want;
    ctrl_valid = 1'b1;
    do
      @(posedge clk);
    while (ctrl_stall);
  endtask

  // Holds the sender back until every expected result has come out.
  task automatic drain_results();
    @(negedge clk);
    ctrl_valid = 1'b0;
    while (pending_points.size() != 0)
      @(posedge clk);
  endtask

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    if (rst)
      curve_stall = 1'b0;
    else
      curve_stall = ($urandom_range(99) < rx_idle_pct);
  end

  // Records each accepted item and checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (ctrl_valid && !ctrl_stall)
        pending_points.push_back(row_typed ? row_want : spline_point(ctrl));
      if (curve_valid && !curve_stall) begin
        if (pending_points.size() == 0) begin
          $display("%0t: result with nothing expected: x=%0d y=%0d clipped=%0b",
                   $time, curve.out_x, curve.out_y, curve.clipped);
          errors++;
        end else begin
          oldest = pending_points.pop_front();
          if (curve.out_x !== oldest.out_x) begin
            $display("%0t: out_x expected %0d, got %0d", $time, oldest.out_x, curve.out_x);
            errors++;
          end
          if (curve.out_y !== oldest.out_y) begin
            $display("%0t: out_y expected %0d, got %0d", $time, oldest.out_y, curve.out_y);
            errors++;
          end
          if (curve.clipped !== oldest.clipped) begin
            $display("%0t: clipped expected %0b, got %0b", $time, oldest.clipped,
                     curve.clipped);
            errors++;
          end
        end
      end
    end
  end

  // Ends a run that hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** catmull_rom_spline_2d_top: FAILED **");
      $finish;
    end
  end

  // Reset, the directed table, three random phases, then the drain and the verdict.
  initial begin
    ctrl_valid = 1'b0;
    ctrl       = '0;
    rst        = 1'b1;

    // Position zero gives the second point and position one the third, so those are typed.
    add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, '0), 1'b1, make_point(0, 0, 1'b0));
    add_row(make_item(0, 0, COORD_MAX, COORD_MIN, 0, 0, 0, 0, '0), 1'b1,
            make_point(COORD_MAX, COORD_MIN, 1'b0));
    add_row(make_item(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                      COORD_MIN, COORD_MIN, '0), 1'b1,
            make_point(COORD_MIN, COORD_MAX, 1'b0));
    add_row(make_item(0, 0, 0, 0, COORD_MIN, COORD_MAX, 0, 0, T_ONE), 1'b1,
            make_point(COORD_MIN, COORD_MAX, 1'b0));
    add_row(make_item(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                      COORD_MIN, COORD_MAX, T_ONE), 1'b1,
            make_point(COORD_MAX, COORD_MIN, 1'b0));
    // Positions above one are clamped to one.
    add_row(make_item(-700, 900, 55, -66, 1234, -4321, 3000, -3000, {T_W{1'b1}}), 1'b1,
            make_point(1234, -4321, 1'b0));
    add_row(make_item(12, 34, 56, 78, -9, -10, 11, -12, T_ONE + 1), 1'b1,
            make_point(-9, -10, 1'b0));
    // Overshoot beyond the top and the bottom of the range saturates.
    add_row(make_item(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                      COORD_MIN, COORD_MAX, 17'h08000), 1'b0, '0);
    add_row(make_item(COORD_MIN, 0, COORD_MAX, 0, COORD_MAX, 0, COORD_MIN, 0, 17'h04000),
            1'b0, '0);
    add_row(make_item(0, COORD_MAX, 0, COORD_MIN, 0, COORD_MIN, 0, COORD_MAX, 17'h0C000),
            1'b0, '0);
    // Constant curves at the extremes, and small positions near both ends.
    add_row(make_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                      COORD_MAX, COORD_MAX, 17'h08000), 1'b0, '0);
    add_row(make_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MIN, COORD_MIN, 17'h13579), 1'b0, '0);
    add_row(make_item(-3, 5, 7, -11, 13, 17, -19, 23, 17'h00001), 1'b0, '0);
    add_row(make_item(-3, 5, 7, -11, 13, 17, -19, 23, 17'h0FFFF), 1'b0, '0);
    add_row(make_item(-1, -1, -1, -1, -1, -1, -1, -1, 17'h0AAAA), 1'b0, '0);
    // Collinear points and a zigzag, each at two positions.
    add_row(make_item(-300, 600, -100, 200, 100, -200, 300, -600, 17'h05555), 1'b0, '0);
    add_row(make_item(-300, 600, -100, 200, 100, -200, 300, -600, 17'h0ABCD), 1'b0, '0);
    add_row(make_item(20000, -20000, -20000, 20000, 20000, -20000, -20000, 20000, 17'h02000),
            1'b0, '0);
    add_row(make_item(20000, -20000, -20000, 20000, 20000, -20000, -20000, 20000, 17'h0E000),
            1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        foreach (directed_rows[i])
          send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        drain_results();
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_item(random_item(), 1'b0, '0);
      if (ph == 0)
        drain_results();
    end

    // Let the pipeline empty and watch for stray results.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("** catmull_rom_spline_2d_top: PASSED **");
    end else begin
      $display("** catmull_rom_spline_2d_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/crs2d_pkg.sv
hw/rtl/crs2d_coef.sv
hw/rtl/crs2d_step.sv
hw/rtl/crs2d_round.sv
hw/rtl/catmull_rom_spline_2d_top.sv
tb/sv/catmull_rom_spline_2d_top_test.sv
